@@ hdl/itsu_pkg.sv @@
// ----------------------------------------------------------------------------
// itsu_pkg
// Shared widths, operation and status codes, and the key memory command
// struct used by the id table search/update/compact unit.
// ----------------------------------------------------------------------------
package itsu_pkg;

    localparam int KEY_W        = 32;
    localparam int SLOT_W       = 6;
    localparam int FILL_W       = 7;
    localparam int STATUS_W     = 2;
    localparam int OP_W         = 3;
    localparam int CAPACITY_DEF = 64;

    // request word: operation, key, new_key, slot, padded to whole bytes
    localparam int IN_BITS  = OP_W + KEY_W + KEY_W + SLOT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    // result word: status, found_slot, entry_value, fill_count
    localparam int OUT_BITS = STATUS_W + SLOT_W + KEY_W + FILL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_DELETE = 3'd1,
        OP_WRITE  = 3'd2,
        OP_SEARCH = 3'd3,
        OP_UPDATE = 3'd4,
        OP_DUMP   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // one write port and one read port per cycle
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } mem_cmd_t;

endpackage

@@ hdl/itsu_keymem.sv @@
// ----------------------------------------------------------------------------
// itsu_keymem
// Key storage: one write and one registered read per cycle, no reset.
// ----------------------------------------------------------------------------
module itsu_keymem #(
    parameter int CAPACITY = itsu_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  itsu_pkg::mem_cmd_t          cmd,
    output logic [itsu_pkg::KEY_W-1:0]  rd_data
);
    import itsu_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic [KEY_W-1:0] mem [CAPACITY];
    logic [KEY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/id_table_search_update_compact_unit.sv @@
// ----------------------------------------------------------------------------
// id_table_search_update_compact_unit
// Dense key table with linear search, update, delete with compaction, and dump.
// ----------------------------------------------------------------------------
// Sequence: append, write and unknown codes go straight to S_RESP for the
//   result; search/update scan at most fill count entries; delete scans,
//   then shifts each later entry down one slot in S_SHIFT.
// Throughput: one request at a time; unstalled dump emits one entry per cycle.
// Reset: fill count and handshakes cleared at once; key memory not cleared.
module id_table_search_update_compact_unit #(
    parameter int CAPACITY = itsu_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // operation[2:0], key[34:3], new_key[66:35], slot[72:67], zero pad
    input  logic [itsu_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status[1:0], found_slot[7:2], entry_value[39:8], fill_count[46:40], pad
    output logic [itsu_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tlast
);
    import itsu_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [KEY_W-1:0]     nkey_reg, nkey_next;
    logic [STATUS_W-1:0]  rstat_reg, rstat_next;
    logic [SLOT_W-1:0]    rslot_reg, rslot_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    mem_cmd_t             mem_cmd;
    logic [KEY_W-1:0]     rd_data;

    logic                 out_free;
    logic                 in_fire;
    logic [CW-1:0]        idx_inc;
    logic                 idx_at_end;
    logic [OP_W-1:0]      in_op;
    logic [KEY_W-1:0]     in_key;
    logic [KEY_W-1:0]     in_nkey;
    logic [SLOT_W-1:0]    in_slot;

    itsu_keymem #(
        .CAPACITY (CAPACITY)
    ) u_keymem (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    // request fields
    assign in_op   = s_tdata[OP_W-1:0];
    assign in_key  = s_tdata[OP_W +: KEY_W];
    assign in_nkey = s_tdata[OP_W + KEY_W +: KEY_W];
    assign in_slot = s_tdata[OP_W + 2*KEY_W +: SLOT_W];

    assign s_tready   = (state_reg == S_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign idx_inc    = CW'(idx_reg) + CW'(1);
    assign idx_at_end = (idx_inc == count_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // sequencer: scan, shift and (unless stalled) dump walk one entry per cycle
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        nkey_next     = nkey_reg;
        rstat_next    = rstat_reg;
        rslot_next    = rslot_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        mem_cmd       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = in_op;
                    key_next   = in_key;
                    nkey_next  = in_nkey;
                    idx_next   = '0;
                    rstat_next = ST_OK;
                    rslot_next = '0;
                    state_next = S_RESP;
                    case (in_op)
                        OP_APPEND:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                rstat_next = ST_FULL;
                            end
                            else
                            begin
                                mem_cmd.wr_en   = 1'b1;
                                mem_cmd.wr_addr = SLOT_W'(count_reg[AW-1:0]);
                                mem_cmd.wr_data = in_key;
                                rslot_next      = SLOT_W'(count_reg[AW-1:0]);
                                count_next      = count_reg + CW'(1);
                            end
                        end
                        OP_WRITE:
                        begin
                            rslot_next = in_slot;
                            if (FILL_W'(in_slot) >= FILL_W'(CAPACITY))
                            begin
                                rstat_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                mem_cmd.wr_en   = 1'b1;
                                mem_cmd.wr_addr = in_slot;
                                mem_cmd.wr_data = in_key;
                            end
                        end
                        OP_DELETE, OP_SEARCH, OP_UPDATE:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = '0;
                                state_next      = S_SCAN;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = '0;
                                state_next      = S_DUMP;
                            end
                        end
                        default:
                        begin
                            rstat_next = ST_OK;
                        end
                    endcase
                end
            end

            // compare the entry read last cycle against the key
            S_SCAN:
            begin
                if (rd_data == key_reg)
                begin
                    rslot_next = SLOT_W'(idx_reg);
                    rstat_next = ST_OK;
                    state_next = S_RESP;
                    if (op_reg == OP_UPDATE)
                    begin
                        mem_cmd.wr_en   = 1'b1;
                        mem_cmd.wr_addr = SLOT_W'(idx_reg);
                        mem_cmd.wr_data = nkey_reg;
                    end
                    else if (op_reg == OP_DELETE)
                    begin
                        if (idx_at_end)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = SLOT_W'(idx_inc);
                            idx_next        = idx_inc[AW-1:0];
                            state_next      = S_SHIFT;
                        end
                    end
                end
                else if (idx_at_end)
                begin
                    rstat_next = ST_NOT_FOUND;
                    rslot_next = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = SLOT_W'(idx_inc);
                    idx_next        = idx_inc[AW-1:0];
                end
            end

            // move entry idx down to idx - 1
            S_SHIFT:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = SLOT_W'(idx_reg - AW'(1));
                mem_cmd.wr_data = rd_data;
                if (idx_at_end)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = SLOT_W'(idx_inc);
                    idx_next        = idx_inc[AW-1:0];
                end
            end

            // one entry per result, read data held while output stalls
            S_DUMP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({FILL_W'(count_reg), rd_data,
                                            SLOT_W'(idx_reg), ST_OK});
                    m_tlast_next  = idx_at_end;
                    if (idx_at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = SLOT_W'(idx_inc);
                        idx_next        = idx_inc[AW-1:0];
                    end
                end
            end

            // single result for every other operation and for an empty dump
            S_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({FILL_W'(count_reg), KEY_W'(0),
                                            rslot_reg, rstat_reg});
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        nkey_reg    <= nkey_next;
        rstat_reg   <= rstat_next;
        rslot_reg   <= rslot_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule
